// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, muted while reset is high
`define AKDD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check a property on every rising edge, reset included
`define AKDD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ----- sv/akdd_pkg.sv -----
`default_nettype none

package akdd_pkg;

   // Keypad geometry
   localparam int NUM_KEYS = 5;
   localparam int ADC_BITS = 12;
   localparam int KEY_SLOTS = 5;
   localparam int NUM_KEYS_USE = (NUM_KEYS < 1) ? 1 : ((NUM_KEYS > KEY_SLOTS) ? KEY_SLOTS : NUM_KEYS);

   // Field widths
   localparam int SAMPLE_W = 12;
   localparam int TIME_W = 32;
   localparam int INTERVAL_W = 16;
   localparam int COUNT_W = 8;
   localparam int CLASS_W = 3;
   localparam int REQ_DATA_W = ((SAMPLE_W + TIME_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((1 + CLASS_W + CLASS_W + 1 + 7) / 8) * 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Sample mask: ADC resolution within the sample field
   localparam int ADC_USE = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
   localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((64'd1 << ADC_USE) - 64'd1);

   // Classes
   localparam logic [CLASS_W-1:0] CLASS_NONE = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_INVALID = 3'd6;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   // Item kinds carried in tuser
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_FETCH = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_ONE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_TWO = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_THREE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_FOUR = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_FIVE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TOLERANCE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_INTERVAL = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_STABLE_LIMIT = 3'd7;

   // Register reset values
   typedef logic [SAMPLE_W-1:0] level_array_type [KEY_SLOTS];
   localparam level_array_type LEVEL_RESET = '{12'd0, 12'd800, 12'd1600, 12'd2400, 12'd3200};
   localparam logic [SAMPLE_W-1:0] TOLERANCE_RESET = 12'd100;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd20;
   localparam logic [COUNT_W-1:0] STABLE_LIMIT_RESET = 8'd3;

   // Result word layout
   typedef struct packed {
      logic                key_pending;
      logic [CLASS_W-1:0]  fetched_key;
      logic [CLASS_W-1:0]  raw_key;
      logic                sample_taken;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- sv/analog_keypad_decoder_debouncer_unit.sv -----
`default_nettype none

// Resistor-ladder keypad decoder with debounce. Each request word is either an
// ADC sample with its millisecond time (tuser 0) or a fetch of the stable key
// (tuser 1); each produces exactly one response word. A sample is taken only
// once sample_interval_ms has passed since the last taken sample, classified
// against the five key levels, and debounced by a saturating repeat count; a
// fetch hands out a pending stable key once. The block takes one word per clock
// while the response side is not stalled; each word passes through the input
// register and then the response register. That rate holds because the update
// of the debounce state does the classification and the count compare in one
// pass, so the next word sees the new state. Write registers through the csr
// port only while no word is in flight; the block does not enforce this.
module analog_keypad_decoder_debouncer_unit
   import akdd_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  [REQ_DATA_W-1:0]      req_tdata,   // adc_sample[11:0], now_ms[43:12], zero pad
   input  wire  [0:0]                 req_tuser,   // func
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // sample_taken, raw_key, fetched_key, key_pending
   input  wire                        csr_wr_en,
   input  wire  [CSR_INDEX_W-1:0]     csr_index,
   input  wire  [CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration
   logic [SAMPLE_W-1:0]   level_ff [KEY_SLOTS];
   logic [SAMPLE_W-1:0]   tol_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [COUNT_W-1:0]    limit_ff;

   // Input register
   logic                  stg_vld_ff;
   logic                  stg_func_ff;
   logic [SAMPLE_W-1:0]   stg_sample_ff;
   logic [TIME_W-1:0]     stg_now_ff;

   // Debounce state
   logic [TIME_W-1:0]     last_time_ff, last_time_in;
   logic [CLASS_W-1:0]    last_class_ff, last_class_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [CLASS_W-1:0]    stable_ff, stable_in;
   logic                  pending_ff, pending_in;

   // Response register
   logic                  rsp_vld_ff;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  advance;
   logic                  fire;
   logic [SAMPLE_W-1:0]   sample_m;
   logic [SAMPLE_W:0]     top_sum;
   logic                  above_top;
   logic [KEY_SLOTS-1:0]  hit;
   logic [SAMPLE_W-1:0]   diff [KEY_SLOTS];
   logic [CLASS_W-1:0]    raw_class;
   logic [TIME_W-1:0]     elapsed;
   logic                  due;
   logic [COUNT_W-1:0]    count_inc;

   // Handshake: the stage moves on when the response register is free or drains
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign fire       = stg_vld_ff && advance;
   assign req_tready = !stg_vld_ff || advance;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_word_ff);

   // Classify the sample against the key levels
   always_comb begin
      sample_m  = stg_sample_ff & ADC_MASK;
      top_sum   = {1'b0, level_ff[NUM_KEYS_USE-1]} + {1'b0, tol_ff};
      above_top = {1'b0, sample_m} > top_sum;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         diff[i] = (sample_m >= level_ff[i]) ? (sample_m - level_ff[i])
                                             : (level_ff[i] - sample_m);
         hit[i]  = (i < NUM_KEYS_USE) && (diff[i] <= tol_ff);
      end
      raw_class = CLASS_INVALID;
      for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            raw_class = CLASS_W'(i + 1);
         end
      end
      if (above_top) begin
         raw_class = CLASS_NONE;
      end
   end

   // Interval check, modulo 2^32
   assign elapsed   = stg_now_ff - last_time_ff;
   assign due       = elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, interval_ff};
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 8'd1;

   // Next debounce state and response word
   always_comb begin
      last_time_in  = last_time_ff;
      last_class_in = last_class_ff;
      count_in      = count_ff;
      stable_in     = stable_ff;
      pending_in    = pending_ff;
      rsp_word_in   = '0;
      if (stg_func_ff == FUNC_FETCH) begin
         if (pending_ff) begin
            pending_in              = 1'b0;
            rsp_word_in.fetched_key = stable_ff;
         end
      end else if (due) begin
         last_time_in             = stg_now_ff;
         rsp_word_in.sample_taken = 1'b1;
         rsp_word_in.raw_key      = raw_class;
         if (raw_class == last_class_ff) begin
            count_in = count_inc;
            if (count_inc >= limit_ff && raw_class != stable_ff) begin
               stable_in = raw_class;
               if (raw_class != CLASS_NONE) begin
                  pending_in = 1'b1;
               end
            end
         end else begin
            last_class_in = raw_class;
            count_in      = '0;
         end
      end
      rsp_word_in.key_pending = pending_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= LEVEL_RESET;
         tol_ff      <= TOLERANCE_RESET;
         interval_ff <= INTERVAL_RESET;
         limit_ff    <= STABLE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_LEVEL_ONE:    level_ff[0] <= csr_wdata[SAMPLE_W-1:0];
            REG_LEVEL_TWO:    level_ff[1] <= csr_wdata[SAMPLE_W-1:0];
            REG_LEVEL_THREE:  level_ff[2] <= csr_wdata[SAMPLE_W-1:0];
            REG_LEVEL_FOUR:   level_ff[3] <= csr_wdata[SAMPLE_W-1:0];
            REG_LEVEL_FIVE:   level_ff[4] <= csr_wdata[SAMPLE_W-1:0];
            REG_TOLERANCE:    tol_ff      <= csr_wdata[SAMPLE_W-1:0];
            REG_INTERVAL:     interval_ff <= csr_wdata[INTERVAL_W-1:0];
            REG_STABLE_LIMIT: limit_ff    <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register: load on every accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
      end else if (req_tready) begin
         stg_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stg_func_ff   <= req_tuser[0];
         stg_sample_ff <= req_tdata[SAMPLE_W-1:0];
         stg_now_ff    <= req_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
      end
   end

   // Debounce state: advance once per processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff  <= '0;
         last_class_ff <= CLASS_NONE;
         count_ff      <= '0;
         stable_ff     <= CLASS_NONE;
         pending_ff    <= 1'b0;
      end else if (fire) begin
         last_time_ff  <= last_time_in;
         last_class_ff <= last_class_in;
         count_ff      <= count_in;
         stable_ff     <= stable_in;
         pending_ff    <= pending_in;
      end
   end

   // Response register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/akdd_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the keypad decoder
module akdd_checker
   import akdd_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready,
   input wire [RSP_DATA_W-1:0]  rsp_tdata
);

   rsp_word_type word;

   assign word = rsp_word_type'(rsp_tdata[$bits(rsp_word_type)-1:0]);

   // Reset empties the response register
   `AKDD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "response valid after reset")

   // A stalled response word holds
   `AKDD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // A sample that was not taken reports no class
   `AKDD_ASSERT(a_skip_no_class, clock, reset, rsp_tvalid && !word.sample_taken |-> word.raw_key == CLASS_NONE, "class on untaken sample")

   // A taken sample never carries a fetched key
   `AKDD_ASSERT(a_taken_no_fetch, clock, reset, rsp_tvalid && word.sample_taken |-> word.fetched_key == CLASS_NONE, "fetched key on sample")

   // Handing out a key clears the pending flag
   `AKDD_ASSERT(a_fetch_clears, clock, reset, rsp_tvalid && word.fetched_key != CLASS_NONE |-> !word.key_pending, "pending after fetch")

endmodule

bind analog_keypad_decoder_debouncer_unit akdd_checker u_akdd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- tb/analog_keypad_decoder_debouncer_unit_tb.sv -----
`timescale 1ns / 100ps

module analog_keypad_decoder_debouncer_unit_tb;
   import akdd_pkg::*;

   typedef struct packed {
      logic [KEY_SLOTS-1:0][SAMPLE_W-1:0] level;
      logic [SAMPLE_W-1:0]                tol;
      logic [INTERVAL_W-1:0]              interval;
      logic [COUNT_W-1:0]                 limit;
   } keypad_cfg_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;   // adc_sample[11:0], now_ms[43:12], zero pad
   logic [0:0]             req_tuser = '0;   // func
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;        // sample_taken, raw_key, fetched_key, key_pending
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predicted debouncer state and the live register settings
   keypad_cfg_type       live_cfg;
   logic [TIME_W-1:0]    last_take_ms = '0;
   logic [CLASS_W-1:0]   last_class_seen = CLASS_NONE;
   logic [COUNT_W-1:0]   repeat_cnt = '0;
   logic [CLASS_W-1:0]   stable_key = CLASS_NONE;
   logic                 key_waiting = 1'b0;

   rsp_word_type         expected_q[$];
   int                   mismatches = 0;
   bit                   idle_on = 1'b1;
   int                   hold_left = 0;
   logic [TIME_W-1:0]    ms_now = '0;

   analog_keypad_decoder_debouncer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic keypad_cfg_type default_cfg();
      keypad_cfg_type c;
      for (int i = 0; i < KEY_SLOTS; i++) c.level[i] = LEVEL_RESET[i];
      c.tol = TOLERANCE_RESET;
      c.interval = INTERVAL_RESET;
      c.limit = STABLE_LIMIT_RESET;
      return c;
   endfunction

   // Class of a sample against the current ladder; sums are kept exact
   function automatic logic [CLASS_W-1:0] classify_sample(input logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W:0]   top;
      logic [SAMPLE_W-1:0] lv;
      logic [SAMPLE_W-1:0] gap;
      top = {1'b0, live_cfg.level[NUM_KEYS_USE-1]} + {1'b0, live_cfg.tol};
      if ({1'b0, s} > top) return CLASS_NONE;
      for (int i = 0; i < NUM_KEYS_USE; i++) begin
         lv = live_cfg.level[i];
         gap = (s >= lv) ? s - lv : lv - s;
         if (gap <= live_cfg.tol) return CLASS_W'(i + 1);
      end
      return CLASS_INVALID;
   endfunction

   // Advance the predicted state by one word and return the response it gives
   function automatic rsp_word_type debounce_step(input logic func,
                                                  input logic [SAMPLE_W-1:0] sample,
                                                  input logic [TIME_W-1:0] now);
      rsp_word_type     r;
      logic [TIME_W-1:0] elapsed;
      logic [CLASS_W-1:0] cls;
      r = '0;
      elapsed = now - last_take_ms;
      if (func == FUNC_FETCH) begin
         if (key_waiting) begin
            key_waiting = 1'b0;
            r.fetched_key = stable_key;
         end
      end else if (elapsed >= TIME_W'(live_cfg.interval)) begin
         last_take_ms = now;
         cls = classify_sample(sample & ADC_MASK);
         r.sample_taken = 1'b1;
         r.raw_key = cls;
         if (cls == last_class_seen) begin
            if (repeat_cnt != COUNT_MAX) repeat_cnt++;
            if (repeat_cnt >= live_cfg.limit && cls != stable_key) begin
               stable_key = cls;
               if (cls != CLASS_NONE) key_waiting = 1'b1;
            end
         end else begin
            last_class_seen = cls;
            repeat_cnt = '0;
         end
      end
      r.key_pending = key_waiting;
      return r;
   endfunction

   // Offer one word, optionally after a gap, and log its expected response
   task automatic send_word(input logic func, input logic [SAMPLE_W-1:0] sample,
                            input logic [TIME_W-1:0] now);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= REQ_DATA_W'({now, sample});
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(debounce_step(func, sample, now));
   endtask

   // Drop valid and hold until every expected word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_TOLERANCE:    live_cfg.tol = val[SAMPLE_W-1:0];
         REG_INTERVAL:     live_cfg.interval = val;
         REG_STABLE_LIMIT: live_cfg.limit = val[COUNT_W-1:0];
         default:          live_cfg.level[idx - REG_LEVEL_ONE] = val[SAMPLE_W-1:0];
      endcase
   endtask

   // Write every register while the block is idle
   task automatic apply_config(input keypad_cfg_type c);
      drain();
      for (int i = 0; i < KEY_SLOTS; i++)
         write_reg(REG_LEVEL_ONE + CSR_INDEX_W'(i), CSR_DATA_W'(c.level[i]));
      write_reg(REG_TOLERANCE, CSR_DATA_W'(c.tol));
      write_reg(REG_INTERVAL, c.interval);
      write_reg(REG_STABLE_LIMIT, CSR_DATA_W'(c.limit));
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic keypad_cfg_type random_cfg();
      keypad_cfg_type c;
      int          spacing;
      int          base;
      if ($urandom_range(0, 1) == 1) begin
         spacing = $urandom_range(100, 800);
         base = $urandom_range(0, 4095 - 4 * spacing);
         for (int i = 0; i < KEY_SLOTS; i++) c.level[i] = SAMPLE_W'(base + i * spacing);
      end else begin
         for (int i = 0; i < KEY_SLOTS; i++) c.level[i] = SAMPLE_W'($urandom_range(0, 4095));
      end
      case ($urandom_range(0, 7))
         0:       c.tol = '0;
         1:       c.tol = '1;
         default: c.tol = SAMPLE_W'($urandom_range(10, 200));
      endcase
      case ($urandom_range(0, 7))
         0:       c.interval = '0;
         1:       c.interval = '1;
         default: c.interval = INTERVAL_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 7))
         0:       c.limit = '0;
         1:       c.limit = COUNT_MAX;
         default: c.limit = COUNT_W'($urandom_range(1, 6));
      endcase
      return c;
   endfunction

   // Runs of samples near one key level, with fetches, early samples and noise
   task automatic run_traffic(input int n_items);
      int                  pick;
      int                  mode;
      int                  run_left;
      int                  spread;
      int                  v;
      logic [SAMPLE_W:0]   top;
      logic [SAMPLE_W-1:0] sample;
      run_left = 0;
      mode = 0;
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(0, 19);
         if (run_left == 0) begin
            mode = $urandom_range(0, 6);
            run_left = $urandom_range(1, 8);
         end
         sample = SAMPLE_W'($urandom_range(0, 4095));
         if (pick < 2) begin
            send_word(FUNC_FETCH, sample, $urandom());
         end else if (pick == 2) begin
            if (live_cfg.interval > 1) ms_now += $urandom_range(0, live_cfg.interval - 1);
            send_word(FUNC_SAMPLE, sample, ms_now);
         end else begin
            ms_now += live_cfg.interval + $urandom_range(0, 5);
            if (pick > 3) begin
               run_left--;
               if (mode < KEY_SLOTS) begin
                  spread = (live_cfg.tol > 200) ? 200 : int'(live_cfg.tol);
                  v = int'(live_cfg.level[mode]) + int'($urandom_range(0, 2 * spread)) - spread;
                  sample = SAMPLE_W'((v < 0) ? 0 : ((v > 4095) ? 4095 : v));
               end else if (mode == KEY_SLOTS) begin
                  top = {1'b0, live_cfg.level[KEY_SLOTS-1]} + {1'b0, live_cfg.tol};
                  sample = (top < 4095) ? SAMPLE_W'($urandom_range(int'(top) + 1, 4095)) : '1;
               end
            end
            send_word(FUNC_SAMPLE, sample, ms_now);
         end
      end
   endtask

   // Ladder at reset values: each level, early samples, latch, fetch, edges
   task automatic test_reset_defaults();
      send_word(FUNC_FETCH, 12'hFFF, 32'hFFFF_FFFF);
      send_word(FUNC_SAMPLE, 12'd800, 32'd20);
      send_word(FUNC_SAMPLE, 12'd800, 32'd25);
      send_word(FUNC_SAMPLE, 12'd810, 32'd40);
      send_word(FUNC_SAMPLE, 12'd790, 32'd60);
      send_word(FUNC_SAMPLE, 12'd900, 32'd80);
      send_word(FUNC_SAMPLE, 12'd700, 32'd100);
      send_word(FUNC_FETCH, 12'd0, 32'd0);
      send_word(FUNC_FETCH, 12'd0, 32'd0);
      send_word(FUNC_SAMPLE, 12'hFFF, 32'd120);
      send_word(FUNC_SAMPLE, 12'd3300, 32'd140);
      send_word(FUNC_SAMPLE, 12'd3301, 32'd160);
      send_word(FUNC_SAMPLE, 12'd400, 32'd180);
      send_word(FUNC_SAMPLE, 12'd0, 32'd200);
      send_word(FUNC_SAMPLE, 12'd2400, 32'd220);
      send_word(FUNC_SAMPLE, 12'd1600, 32'd240);
   endtask

   // Zero limit, invalid and no-key latching, time wrap, extreme levels
   task automatic test_corner_cases();
      keypad_cfg_type c;
      c = default_cfg();
      c.interval = '0;
      c.limit = '0;
      c.tol = '0;
      apply_config(c);
      send_word(FUNC_SAMPLE, 12'd0, 32'd5);
      send_word(FUNC_SAMPLE, 12'd0, 32'd5);
      send_word(FUNC_SAMPLE, 12'd800, 32'd5);
      send_word(FUNC_FETCH, 12'd0, 32'd5);
      send_word(FUNC_SAMPLE, 12'd401, 32'd5);
      send_word(FUNC_SAMPLE, 12'd401, 32'd5);
      send_word(FUNC_FETCH, 12'd0, 32'd5);
      send_word(FUNC_SAMPLE, 12'hFFF, 32'd5);
      send_word(FUNC_SAMPLE, 12'hFFF, 32'd5);
      send_word(FUNC_FETCH, 12'd0, 32'd5);
      // time wrap with the longest interval
      c.interval = '1;
      c.level = '1;
      c.tol = '1;
      apply_config(c);
      send_word(FUNC_SAMPLE, 12'hFFF, 32'hFFFF_FF00);
      send_word(FUNC_SAMPLE, 12'd0, 32'h0000_FEFF);
      send_word(FUNC_SAMPLE, 12'd0, 32'h0001_FEFD);
      send_word(FUNC_SAMPLE, 12'd0, 32'h0001_FEFE);
      c.tol = '0;
      apply_config(c);
      send_word(FUNC_SAMPLE, 12'hFFF, 32'hFFFF_0000);
      send_word(FUNC_SAMPLE, 12'd0, 32'h7FFF_0000);
   endtask

   // Hold one key long enough to saturate the repeat count at the top limit
   task automatic test_count_saturation();
      keypad_cfg_type c;
      c = default_cfg();
      c.interval = '0;
      c.limit = COUNT_MAX;
      apply_config(c);
      for (int k = 0; k < 262; k++)
         send_word(FUNC_SAMPLE, 12'd1600, 32'(k));
      send_word(FUNC_FETCH, 12'd0, 32'd0);
      send_word(FUNC_SAMPLE, 12'd2400, 32'd300);
      send_word(FUNC_FETCH, 12'd0, 32'd0);
   endtask

   // Stall the response side for a long stretch while words keep coming
   task automatic test_backpressure();
      apply_config(default_cfg());
      idle_on = 1'b0;
      hold_left = 40;
      ms_now = $urandom();
      run_traffic(24);
      drain();
      idle_on = 1'b1;
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 6; p++) begin
         apply_config(random_cfg());
         ms_now = $urandom();
         run_traffic(100);
      end
   endtask

   task automatic test_steady_finish();
      apply_config(random_cfg());
      idle_on = 1'b0;
      run_traffic(150);
   endtask

   // Response ready: long hold when asked, otherwise random stall bursts
   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 10) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each response word with the oldest expected one
   always @(posedge clock) begin : word_checker
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_word_type'(rsp_tdata);
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected word taken=%0d raw=%0d fetched=%0d pending=%0d",
                        $realtime, got.sample_taken, got.raw_key, got.fetched_key,
                        got.key_pending);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: expected taken=%0d raw=%0d fetched=%0d pending=%0d, ",
                            "got %0d %0d %0d %0d"},
                           $realtime, want.sample_taken, want.raw_key, want.fetched_key,
                           want.key_pending, got.sample_taken, got.raw_key, got.fetched_key,
                           got.key_pending);
            end
         end
      end
   end

   initial begin
      live_cfg = default_cfg();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_corner_cases();
      test_count_saturation();
      test_backpressure();
      test_random_phases();
      test_steady_finish();
      drain();
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- analog_keypad_decoder_debouncer_unit.f -----
+incdir+sv
sv/akdd_pkg.sv
sv/analog_keypad_decoder_debouncer_unit.sv
sv/akdd_checker.sv
tb/analog_keypad_decoder_debouncer_unit_tb.sv
